@@ rtl/rrba_pkg.sv @@
// Package for the random run bitmap allocator.
// Holds the request/response item structs, status and action codes, and the
// divider request struct. No dependencies.
package rrba_pkg;

   // Field widths fixed by the item formats
   localparam int ADDR_W      = 64;
   localparam int BYTES_W     = 48;
   localparam int ALIGN_W     = 6;
   localparam int RAND_W      = 32;
   localparam int RUN_START_W = 8;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 9;

   // Reset value of the minimum free run count register
   localparam logic [CFG_W-1:0] MIN_FREE_RUNS_RESET = 9'd100;

   // Smallest legal alignment shift for a place item
   localparam logic [ALIGN_W-1:0] MIN_ALIGN_SHIFT = 6'd21;

   // Action codes
   localparam logic ACTION_RESERVE = 1'b0;
   localparam logic ACTION_PLACE   = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   typedef struct packed {
      logic                   action;
      logic [ADDR_W-1:0]      base_address;
      logic [BYTES_W-1:0]     byte_count;
      logic [ALIGN_W-1:0]     align_shift;
      logic [RAND_W-1:0]      random_for_run;
      logic [RAND_W-1:0]      random_for_offset;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      placed_address;
      logic [RUN_START_W-1:0] run_start;
      logic [STATUS_W-1:0]    status;
   } rsp_type;

   // Start command and dividend for the shared modulo unit
   typedef struct packed {
      logic              start;
      logic [RAND_W-1:0] dividend;
   } div_req_type;

endpackage

@@ rtl/rrba_modulo_unit.sv @@
// Iterative restoring modulo unit: remainder of a 32-bit word by a narrow divisor.
// One quotient bit per cycle. Depends on rrba_pkg.
module rrba_modulo_unit #(
   parameter int DIV_W = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rrba_pkg::div_req_type div_req,
   input  logic [DIV_W-1:0]     divisor,
   output logic                 done,
   output logic [DIV_W-1:0]     remainder
);

   localparam int RW    = rrba_pkg::RAND_W;
   localparam int CNT_W = $clog2(RW + 1);

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   div_state_type     state_ff;
   logic [RW-1:0]     dividend_ff;
   logic [DIV_W-1:0]  divisor_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              done_ff;

   logic [DIV_W:0]    rem_shift;
   logic [DIV_W:0]    rem_diff;
   logic [DIV_W-1:0]  rem_in;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      rem_shift = {rem_ff, dividend_ff[RW-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      if (rem_diff[DIV_W]) begin
         rem_in = rem_shift[DIV_W-1:0];
      end else begin
         rem_in = rem_diff[DIV_W-1:0];
      end
   end

   // Sequence the bit steps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= DIV_IDLE;
         done_ff     <= 1'b0;
         count_ff    <= '0;
         rem_ff      <= '0;
         dividend_ff <= '0;
         divisor_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DIV_IDLE: begin
               if (div_req.start) begin
                  dividend_ff <= div_req.dividend;
                  divisor_ff  <= divisor;
                  rem_ff      <= '0;
                  count_ff    <= CNT_W'(RW);
                  state_ff    <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               dividend_ff <= {dividend_ff[RW-2:0], 1'b0};
               rem_ff      <= rem_in;
               count_ff    <= count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DIV_IDLE;
               end
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/random_run_bitmap_allocator.sv @@
// Top level of the random run bitmap allocator: slot bitmap, sequencer and
// address math. Depends on rrba_pkg and rrba_modulo_unit.
//
//  channel   ports                                   handshake
//  request   start, busy, req_item                   taken when start & !busy
//  response  rsp_strobe, rsp_item                    one-cycle strobe, no stall
//  config    csr_write_enable, csr_write_data        written on enable
//
// A valid reserve item passes CHECK and RES_RANGE, then marks one slot a cycle.
// A place item of n slots walks the bitmap one slot a cycle twice (a full
// count pass, then a pick pass that stops at the chosen run), runs the
// shared modulo unit twice and marks one slot a cycle.
// Bad items go from the checks straight to RESPOND; items short of free
// runs answer after the count pass. The strobe follows the busy cycles.
// Reset clears the bitmap at once; no clearing pass. busy stays high from
// acceptance until the response strobe; the response side cannot stall.
module random_run_bitmap_allocator #(
   parameter int SLOT_COUNT = 256,
   parameter int SLOT_SHIFT = 39
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rrba_pkg::req_type                  req_item,
   output logic                               rsp_strobe,
   output rrba_pkg::rsp_type                  rsp_item,
   input  logic                               csr_write_enable,
   input  logic [rrba_pkg::CFG_W-1:0]         csr_write_data
);

   localparam int AW      = rrba_pkg::ADDR_W;
   localparam int BW      = rrba_pkg::BYTES_W;
   localparam int CW      = rrba_pkg::CFG_W;
   localparam int START_W = rrba_pkg::RUN_START_W;
   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int RUN_W   = $clog2(SLOT_COUNT + 1);
   localparam int OFS_W   = SLOT_SHIFT - 20;
   localparam int DIV_W   = (OFS_W > RUN_W) ? OFS_W : RUN_W;
   localparam int HI_W    = AW - SLOT_SHIFT;
   localparam int HI1_W   = HI_W + 1;

   localparam logic [AW-1:0] AREA_BASE = AW'(0) - (AW'(SLOT_COUNT) << SLOT_SHIFT);
   localparam logic [AW-1:0] SLOT_MASK = (AW'(1) << SLOT_SHIFT) - AW'(1);
   localparam logic [HI_W-1:0] AREA_HI = AREA_BASE[AW-1:SLOT_SHIFT];

   typedef enum logic [3:0] {
      IDLE,
      CHECK,
      RES_RANGE,
      PLACE_CHECK,
      SCAN_COUNT,
      RUN_CHECK,
      RUN_DIV,
      SCAN_PICK,
      OFS_DIFF,
      OFS_CALC,
      OFS_DIV,
      ADDR_CALC,
      MARK,
      RESPOND
   } state_type;

   state_type                       state_ff;
   rrba_pkg::req_type               req_ff;
   logic [CW-1:0]                   min_free_runs_ff;
   logic [SLOT_COUNT-1:0]           slot_taken_ff;
   logic [AW:0]                     sum_ff;
   logic [RUN_W-1:0]                n_ff;
   logic [SLOT_W-1:0]               i_ff;
   logic [RUN_W-1:0]                free_len_ff;
   logic [RUN_W-1:0]                runs_ff;
   logic [RUN_W-1:0]                pick_ff;
   logic [SLOT_W-1:0]               start_ff;
   logic [SLOT_W-1:0]               last_ff;
   logic [SLOT_SHIFT-1:0]           diff_ff;
   logic [OFS_W-1:0]                idx_ff;
   logic [AW-1:0]                   placed_addr_ff;
   logic [rrba_pkg::STATUS_W-1:0]   status_ff;
   logic                            rsp_strobe_ff;
   rrba_pkg::rsp_type               rsp_item_ff;

   logic [AW:0]                     sum_in;
   logic                            count_zero;
   logic [HI_W-1:0]                 base_hi;
   logic                            res_bad;
   logic [HI1_W-1:0]                last_wide;
   logic [SLOT_W-1:0]               first_slot;
   logic [SLOT_W-1:0]               last_slot;
   logic                            place_bad;
   logic                            taken_bit;
   logic [RUN_W-1:0]                free_len_in;
   logic                            run_hit;
   logic                            scan_end;
   logic                            too_few;
   logic [SLOT_W-1:0]               start_in;
   logic [BW-1:0]                   diff_in;
   logic [SLOT_SHIFT-1:0]           diff_shifted;
   logic [OFS_W-1:0]                offsets_in;
   logic [AW-1:0]                   addr_in;
   rrba_pkg::div_req_type           div_req;
   logic [DIV_W-1:0]                div_divisor;
   logic                            div_done;
   logic [DIV_W-1:0]                div_rem;

   // Shared modulo unit for the run pick and the offset pick
   rrba_modulo_unit #(
      .DIV_W (DIV_W)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Front checks: one add feeds either the range end or the slot round-up
   always_comb begin
      if (req_ff.action == rrba_pkg::ACTION_PLACE) begin
         sum_in = {1'b0, SLOT_MASK} + (AW + 1)'(req_ff.byte_count);
      end else begin
         sum_in = {1'b0, req_ff.base_address} + (AW + 1)'(req_ff.byte_count);
      end
      count_zero = (req_ff.byte_count == '0);
      base_hi    = req_ff.base_address[AW-1:SLOT_SHIFT];
      res_bad    = count_zero || (base_hi < AREA_HI) || (sum_ff[AW] && (|sum_ff[AW-1:0]));
      last_wide  = sum_ff[AW:SLOT_SHIFT] - {1'b0, AREA_HI}
                   - HI1_W'(sum_ff[SLOT_SHIFT-1:0] == '0);
      first_slot = SLOT_W'(base_hi - AREA_HI);
      last_slot  = SLOT_W'(last_wide);
      place_bad  = count_zero
                   || (req_ff.align_shift < rrba_pkg::MIN_ALIGN_SHIFT)
                   || (req_ff.align_shift > rrba_pkg::ALIGN_W'(SLOT_SHIFT))
                   || (sum_ff[AW:SLOT_SHIFT] > HI1_W'(SLOT_COUNT));
   end

   // Free-run tracking over the slot walk: a run of n ends at slot i
   always_comb begin
      taken_bit = slot_taken_ff[i_ff];
      if (taken_bit) begin
         free_len_in = '0;
      end else begin
         free_len_in = free_len_ff + RUN_W'(1);
      end
      run_hit  = (free_len_in >= n_ff);
      scan_end = (i_ff == SLOT_W'(SLOT_COUNT - 1));
      too_few  = (runs_ff == '0) || (CW'(runs_ff) < min_free_runs_ff);
      start_in = SLOT_W'(RUN_W'(i_ff) + RUN_W'(1) - n_ff);
   end

   // Offset count and final address
   always_comb begin
      diff_in      = (BW'(n_ff) << SLOT_SHIFT) - req_ff.byte_count;
      diff_shifted = diff_ff >> req_ff.align_shift;
      offsets_in   = OFS_W'(diff_shifted) + OFS_W'(1);
      addr_in      = (AREA_BASE + (AW'(start_ff) << SLOT_SHIFT))
                     | (AW'(idx_ff) << req_ff.align_shift);
   end

   // Drive the modulo unit
   always_comb begin
      div_req.start = ((state_ff == RUN_CHECK) && !too_few) || (state_ff == OFS_CALC);
      if (state_ff == OFS_CALC) begin
         div_req.dividend = req_ff.random_for_offset;
         div_divisor      = DIV_W'(offsets_in);
      end else begin
         div_req.dividend = req_ff.random_for_run;
         div_divisor      = DIV_W'(runs_ff);
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_free_runs_ff <= rrba_pkg::MIN_FREE_RUNS_RESET;
      end else if (csr_write_enable) begin
         min_free_runs_ff <= csr_write_data;
      end
   end

   // Sequencer, bitmap and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         slot_taken_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         i_ff          <= '0;
         free_len_ff   <= '0;
         runs_ff       <= '0;
         pick_ff       <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               sum_ff <= sum_in;
               if (req_ff.action == rrba_pkg::ACTION_PLACE) begin
                  state_ff <= PLACE_CHECK;
               end else begin
                  state_ff <= RES_RANGE;
               end
            end
            RES_RANGE: begin
               placed_addr_ff <= '0;
               if (res_bad) begin
                  start_ff  <= '0;
                  status_ff <= rrba_pkg::STATUS_BAD;
                  state_ff  <= RESPOND;
               end else begin
                  start_ff  <= first_slot;
                  last_ff   <= last_slot;
                  i_ff      <= first_slot;
                  status_ff <= rrba_pkg::STATUS_OK;
                  state_ff  <= MARK;
               end
            end
            PLACE_CHECK: begin
               if (place_bad) begin
                  placed_addr_ff <= '0;
                  start_ff       <= '0;
                  status_ff      <= rrba_pkg::STATUS_BAD;
                  state_ff       <= RESPOND;
               end else begin
                  n_ff        <= RUN_W'(sum_ff[AW:SLOT_SHIFT]);
                  i_ff        <= '0;
                  free_len_ff <= '0;
                  runs_ff     <= '0;
                  state_ff    <= SCAN_COUNT;
               end
            end
            SCAN_COUNT: begin
               free_len_ff <= free_len_in;
               if (run_hit) begin
                  runs_ff <= runs_ff + RUN_W'(1);
               end
               if (scan_end) begin
                  state_ff <= RUN_CHECK;
               end else begin
                  i_ff <= i_ff + SLOT_W'(1);
               end
            end
            RUN_CHECK: begin
               if (too_few) begin
                  placed_addr_ff <= '0;
                  start_ff       <= '0;
                  status_ff      <= rrba_pkg::STATUS_FEW;
                  state_ff       <= RESPOND;
               end else begin
                  state_ff <= RUN_DIV;
               end
            end
            RUN_DIV: begin
               if (div_done) begin
                  pick_ff     <= RUN_W'(div_rem);
                  i_ff        <= '0;
                  free_len_ff <= '0;
                  state_ff    <= SCAN_PICK;
               end
            end
            SCAN_PICK: begin
               free_len_ff <= free_len_in;
               if (run_hit && (pick_ff == '0)) begin
                  start_ff <= start_in;
                  last_ff  <= i_ff;
                  state_ff <= OFS_DIFF;
               end else begin
                  if (run_hit) begin
                     pick_ff <= pick_ff - RUN_W'(1);
                  end
                  i_ff <= i_ff + SLOT_W'(1);
               end
            end
            OFS_DIFF: begin
               diff_ff  <= diff_in[SLOT_SHIFT-1:0];
               state_ff <= OFS_CALC;
            end
            OFS_CALC: begin
               state_ff <= OFS_DIV;
            end
            OFS_DIV: begin
               if (div_done) begin
                  idx_ff   <= OFS_W'(div_rem);
                  state_ff <= ADDR_CALC;
               end
            end
            ADDR_CALC: begin
               placed_addr_ff <= addr_in;
               status_ff      <= rrba_pkg::STATUS_OK;
               i_ff           <= start_ff;
               state_ff       <= MARK;
            end
            MARK: begin
               slot_taken_ff[i_ff] <= 1'b1;
               if (i_ff == last_ff) begin
                  state_ff <= RESPOND;
               end else begin
                  i_ff <= i_ff + SLOT_W'(1);
               end
            end
            RESPOND: begin
               rsp_strobe_ff              <= 1'b1;
               rsp_item_ff.placed_address <= placed_addr_ff;
               rsp_item_ff.run_start      <= START_W'(start_ff);
               rsp_item_ff.status         <= status_ff;
               state_ff                   <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

@@ tb/random_run_bitmap_allocator_tb.sv @@
// Self-checking testbench for random_run_bitmap_allocator: directed rows, then
// random reserve/place items under several free-run thresholds.
// Depends on rrba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module random_run_bitmap_allocator_tb;
   import rrba_pkg::*;

   localparam int SLOT_COUNT  = 256;
   localparam int SLOT_SHIFT  = 39;
   localparam int PHASE_ITEMS = 165;
   localparam int SETTLE      = 8;
   localparam int DRAIN_BOUND = 5000;
   localparam longint unsigned CYCLE_LIMIT = 5000000;

   localparam logic [63:0] SLOT_BYTES = 64'd1 << SLOT_SHIFT;
   localparam logic [63:0] AREA_BASE  = 64'd0 - (64'(SLOT_COUNT) << SLOT_SHIFT);

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type answer;
   } stim_row_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_item = '0;
   logic              rsp_strobe;
   rsp_type           rsp_item;
   logic              csr_write_enable = 1'b0;
   logic [CFG_W-1:0]  csr_write_data = '0;

   // Shadow of the allocator state
   logic [SLOT_COUNT-1:0] slot_map = '0;
   logic [CFG_W-1:0]      min_runs_setting = MIN_FREE_RUNS_RESET;

   rsp_type      answers_due[$];
   stim_row_type stim_rows[$];

   int              errors = 0;
   int              items_sent = 0;
   int              placed_cnt = 0;
   int              reserved_cnt = 0;
   int              few_cnt = 0;
   int              rejected_cnt = 0;
   int              settings_cnt = 0;
   int              quiet_left = 0;
   bit              gaps_on = 1'b1;
   longint unsigned cycles = 0;

   random_run_bitmap_allocator #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_SHIFT(SLOT_SHIFT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers still due", cycles,
                  answers_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Work out the allocator's answer to one item and update the slot map
   function automatic rsp_type allocate_answer(input req_type rq);
      rsp_type     ans;
      logic [63:0] count;
      logic [63:0] first_slot;
      logic [63:0] last_slot;
      logic [63:0] need;
      logic [63:0] pick;
      logic [63:0] offsets;
      logic [63:0] idx;
      int          n_slots;
      int          runs;
      int          streak;
      int          chosen;
      ans = '0;
      ans.status = STATUS_OK;
      count = 64'(rq.byte_count);
      if (rq.action == ACTION_RESERVE) begin
         // Range must sit inside the slot area and not wrap past the top
         if (count == 0 || rq.base_address < AREA_BASE || count - 1 > ~rq.base_address) begin
            ans.status = STATUS_BAD;
         end else begin
            first_slot = (rq.base_address - AREA_BASE) >> SLOT_SHIFT;
            last_slot  = (rq.base_address + (count - 1) - AREA_BASE) >> SLOT_SHIFT;
            for (int s = int'(first_slot); s <= int'(last_slot); s++)
               slot_map[s] = 1'b1;
            ans.run_start = first_slot[RUN_START_W-1:0];
         end
         return ans;
      end
      if (count == 0 || rq.align_shift < MIN_ALIGN_SHIFT
          || int'(rq.align_shift) > SLOT_SHIFT) begin
         ans.status = STATUS_BAD;
         return ans;
      end
      need = (count + SLOT_BYTES - 1) >> SLOT_SHIFT;
      if (need > 64'(SLOT_COUNT)) begin
         ans.status = STATUS_BAD;
         return ans;
      end
      n_slots = int'(need);
      // Count free windows of n_slots: a window ends wherever the free streak reaches n_slots
      runs = 0;
      streak = 0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         streak = slot_map[s] ? 0 : streak + 1;
         if (streak >= n_slots)
            runs++;
      end
      if (runs == 0 || runs < int'(min_runs_setting)) begin
         ans.status = STATUS_FEW;
         return ans;
      end
      // Take the window whose rank is the run word modulo the count
      pick = 64'(rq.random_for_run) % 64'(runs);
      streak = 0;
      chosen = 0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         streak = slot_map[s] ? 0 : streak + 1;
         if (streak >= n_slots) begin
            if (pick == 0) begin
               chosen = s - n_slots + 1;
               break;
            end
            pick--;
         end
      end
      for (int s = chosen; s < chosen + n_slots; s++)
         slot_map[s] = 1'b1;
      offsets = 64'd1 + (((need << SLOT_SHIFT) - count) >> rq.align_shift);
      idx = 64'(rq.random_for_offset) % offsets;
      ans.placed_address = AREA_BASE + (64'(chosen) << SLOT_SHIFT) + (idx << rq.align_shift);
      ans.run_start = chosen[RUN_START_W-1:0];
      return ans;
   endfunction

   // Every field fully random: mostly rejected, covers all field bits
   function automatic req_type scrambled_item();
      req_type rq;
      rq.action            = 1'($urandom_range(0, 1));
      rq.base_address      = rand64();
      rq.byte_count        = 48'(rand64());
      rq.align_shift       = 6'($urandom);
      rq.random_for_run    = $urandom;
      rq.random_for_offset = $urandom;
      return rq;
   endfunction

   // Mostly well-formed items with small regions, some noise
   function automatic req_type random_item();
      req_type     rq;
      int          kind;
      int          n_slots;
      int          span;
      logic [63:0] slot;
      rq = scrambled_item();
      kind = int'($urandom_range(0, 99));
      if (kind < 55) begin
         rq.action = ACTION_PLACE;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: n_slots = 1;
            6, 7:             n_slots = int'($urandom_range(2, 4));
            8:                n_slots = int'($urandom_range(5, 16));
            default:          n_slots = int'($urandom_range(17, SLOT_COUNT));
         endcase
         rq.byte_count = 48'((64'(n_slots - 1) << SLOT_SHIFT)
                             + (rand64() & (SLOT_BYTES - 1)) + 64'd1);
         if ($urandom_range(0, 9) != 0)
            rq.align_shift = 6'($urandom_range(MIN_ALIGN_SHIFT, SLOT_SHIFT));
      end else if (kind < 85) begin
         rq.action = ACTION_RESERVE;
         slot = 64'($urandom_range(0, SLOT_COUNT - 1));
         span = int'($urandom_range(1, 3));
         rq.base_address = AREA_BASE + (slot << SLOT_SHIFT) + (rand64() & (SLOT_BYTES - 1));
         rq.byte_count = 48'((rand64() % (64'(span) << SLOT_SHIFT)) + 64'd1);
      end
      return rq;
   endfunction

   task automatic add_row(input logic act, input logic [63:0] base, input logic [63:0] count,
                          input int ashift, input logic [31:0] r_run, input logic [31:0] r_off,
                          input bit typed, input int start_slot,
                          input logic [STATUS_W-1:0] status);
      stim_row_type row;
      row.item.action            = act;
      row.item.base_address      = base;
      row.item.byte_count        = count[BYTES_W-1:0];
      row.item.align_shift       = 6'(ashift);
      row.item.random_for_run    = r_run;
      row.item.random_for_offset = r_off;
      row.typed                  = typed;
      row.answer.placed_address  = '0;
      row.answer.run_start       = 8'(start_slot);
      row.answer.status          = status;
      stim_rows.push_back(row);
   endtask

   // Hold the request line low for a random burst, or keep it busy
   task automatic pause_sender();
      int n;
      n = 0;
      if (!gaps_on)
         return;
      if (quiet_left > 0) begin
         quiet_left--;
         return;
      end
      case ($urandom_range(0, 5))
         0, 1: n = int'($urandom_range(1, 19));
         2:    quiet_left = int'($urandom_range(5, 30));
         default: n = 0;
      endcase
      repeat (n) begin
         start <= 1'b0;
         req_item <= scrambled_item();
         @(posedge clock);
      end
   endtask

   // Offer one item, wait for acceptance, log its answer
   task automatic issue(input req_type rq, input bit typed, input rsp_type typed_ans);
      rsp_type predicted;
      start <= 1'b1;
      req_item <= rq;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = allocate_answer(rq);
      answers_due.push_back(typed ? typed_ans : predicted);
      items_sent++;
      case (predicted.status)
         STATUS_OK: begin
            if (rq.action == ACTION_PLACE)
               placed_cnt++;
            else
               reserved_cnt++;
         end
         STATUS_FEW: few_cnt++;
         default:    rejected_cnt++;
      endcase
      pause_sender();
   endtask

   // Drop the request line and wait for all answers to come back
   task automatic drain();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (answers_due.size() != 0 && waited < DRAIN_BOUND) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_min_runs(input logic [CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      min_runs_setting = value;
      settings_cnt++;
   endtask

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
   endtask

   // Check every answer against the oldest one due
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected answer, expected none, got %h", $time, rsp_item);
         end else begin
            want = answers_due.pop_front();
            if (rsp_item.placed_address !== want.placed_address)
               report_field("placed_address", want.placed_address, rsp_item.placed_address);
            if (rsp_item.run_start !== want.run_start)
               report_field("run_start", 64'(want.run_start), 64'(rsp_item.run_start));
            if (rsp_item.status !== want.status)
               report_field("status", 64'(want.status), 64'(rsp_item.status));
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] threshold_plan [6];
      rsp_type          unused_ans;
      unused_ans = '0;
      threshold_plan = '{9'd256, 9'd511, 9'd100, 9'd0, 9'd0, 9'd1};
      threshold_plan[3] = 9'($urandom_range(2, 255));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: rejects, extremes, repeated reserve, then predicted places
      add_row(ACTION_RESERVE, AREA_BASE, 0, 0, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, 0, 21, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_RESERVE, 64'd0, 1, 0, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_RESERVE, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_RESERVE, '1, 2, 0, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_RESERVE, AREA_BASE, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, 1, 20, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, 1, 40, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, 1, 63, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, 1, 0, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, (64'd1 << 47) + 1, 39, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_PLACE, 0, 48'hFFFF_FFFF_FFFF, 39, 0, 0, 1, 0, STATUS_BAD);
      add_row(ACTION_RESERVE, '1, 1, 0, 0, 0, 1, 255, STATUS_OK);
      add_row(ACTION_RESERVE, AREA_BASE, 1, 0, 0, 0, 1, 0, STATUS_OK);
      add_row(ACTION_RESERVE, AREA_BASE + (64'd10 << SLOT_SHIFT) + 5, 64'd3 << SLOT_SHIFT,
              0, 0, 0, 1, 10, STATUS_OK);
      add_row(ACTION_RESERVE, AREA_BASE + (64'd10 << SLOT_SHIFT) + 5, 64'd3 << SLOT_SHIFT,
              0, 0, 0, 1, 10, STATUS_OK);
      add_row(ACTION_RESERVE, '1, 1, 0, 0, 0, 1, 255, STATUS_OK);
      add_row(ACTION_PLACE, 0, 64'd1 << 47, 39, 0, 0, 1, 0, STATUS_FEW);
      add_row(ACTION_PLACE, 0, 64'd250 << SLOT_SHIFT, 39, 0, 0, 1, 0, STATUS_FEW);
      add_row(ACTION_PLACE, 0, 1, 21, 0, 0, 0, 0, STATUS_OK);
      add_row(ACTION_PLACE, '1, SLOT_BYTES, 39, '1, '1, 0, 0, STATUS_OK);
      add_row(ACTION_PLACE, 0, SLOT_BYTES + 1, 30, $urandom, $urandom, 0, 0, STATUS_OK);
      add_row(ACTION_PLACE, 0, 64'd40 << SLOT_SHIFT, 35, $urandom, $urandom, 0, 0, STATUS_OK);
      add_row(ACTION_PLACE, 0, 1, 39, $urandom, '1, 0, 0, STATUS_OK);
      add_row(ACTION_PLACE, 0, SLOT_BYTES - (64'd1 << 21) + 1, 21, '1, '1, 0, 0, STATUS_OK);

      foreach (stim_rows[i])
         issue(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].answer);
      drain();

      // Random phases, thresholds ordered so the map fills late
      foreach (threshold_plan[p]) begin
         write_min_runs(threshold_plan[p]);
         gaps_on = (p != 5);
         repeat (PHASE_ITEMS)
            issue(random_item(), 1'b0, unused_ans);
         if (p == 5) begin
            // Fill the whole area, then a place must find no run
            issue('{ACTION_RESERVE, AREA_BASE, 48'h8000_0000_0000, 6'd0, 32'd0, 32'd0},
                  1'b0, unused_ans);
            issue('{ACTION_PLACE, 64'd0, 48'd1, 6'd21, 32'd0, 32'd0}, 1'b0, unused_ans);
         end
         drain();
      end

      if (answers_due.size() != 0) begin
         $display("%0t: %0d answers never arrived", $time, answers_due.size());
         errors += answers_due.size();
      end
      $display("Covered %0d items: %0d placed, %0d reserved, %0d short of free runs, %0d rejected",
               items_sent, placed_cnt, reserved_cnt, few_cnt, rejected_cnt);
      $display("Used %0d threshold settings; %0d of %0d slots taken at the end, %0d mismatches",
               settings_cnt, $countones(slot_map), SLOT_COUNT, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rrba_pkg.sv
rtl/rrba_modulo_unit.sv
rtl/random_run_bitmap_allocator.sv
tb/random_run_bitmap_allocator_tb.sv
